// File: hdl/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/risc_alu_pkg.sv
package risc_alu_pkg;

	localparam int RegCount = 32;
	localparam int RegIdxW  = $clog2(RegCount);

	localparam int InW  = 40;
	localparam int OutW = 64;

	typedef enum logic [4:0] {
		OP_ADD    = 5'd0,
		OP_ADC    = 5'd1,
		OP_ADIW   = 5'd2,
		OP_AND    = 5'd3,
		OP_ANDI   = 5'd4,
		OP_EOR    = 5'd5,
		OP_COM    = 5'd6,
		OP_ASR    = 5'd7,
		OP_DEC    = 5'd8,
		OP_CP     = 5'd9,
		OP_CPC    = 5'd10,
		OP_CPI    = 5'd11,
		OP_CBR    = 5'd12,
		OP_CLR    = 5'd13,
		OP_BSET   = 5'd14,
		OP_BCLR   = 5'd15,
		OP_BST    = 5'd16,
		OP_BLD    = 5'd17,
		OP_BRBS   = 5'd18,
		OP_BRBC   = 5'd19,
		OP_CPSE   = 5'd20,
		OP_FMUL   = 5'd21,
		OP_FMULS  = 5'd22,
		OP_FMULSU = 5'd23,
		OP_IJMP   = 5'd24
	} op_t;

	localparam int FC = 0;
	localparam int FZ = 1;
	localparam int FN = 2;
	localparam int FV = 3;
	localparam int FS = 4;
	localparam int FH = 5;
	localparam int FT = 6;

	typedef struct packed {
		logic [4:0] opcode;
		logic [4:0] dest_index;
		logic [4:0] source_index;
		logic [7:0] immediate;
		logic [2:0] bit_index;
		logic signed [6:0] branch_offset;
	} instr_t;

	typedef struct packed {
		logic        write_enable;
		logic [4:0]  write_index;
		logic [7:0]  write_value;
		logic        pair_enable;
		logic [4:0]  pair_index;
		logic [15:0] pair_value;
		logic [7:0]  status_flags;
		logic [15:0] next_pc;
	} result_t;

	function automatic logic [4:0] reduce_idx(input logic [4:0] i);
		reduce_idx = 5'((32'(i)) % RegCount);
	endfunction

endpackage

// File: hdl/risc_alu_exec.sv
// Combinational execute: operands, flags and pc in, result out
module risc_alu_exec (
	input  risc_alu_pkg::instr_t  ins,
	input  logic [7:0]            d,
	input  logic [7:0]            s,
	input  logic [7:0]            plo,
	input  logic [7:0]            phi,
	input  logic [7:0]            zlo,
	input  logic [7:0]            zhi,
	input  logic [7:0]            sreg,
	input  logic [15:0]           pc,
	output risc_alu_pkg::result_t res
);

	always_comb begin
		logic [7:0]  f, r, sub_s;
		logic        cin, d7, s7, r7, d3, s3, r3;
		logic [15:0] old, pr, prod, npc, off;
		logic signed [16:0] sp;
		logic [4:0]  rd;
		f = sreg;
		r = '0;
		sub_s = '0;
		cin = 1'b0;
		old = '0;
		pr = '0;
		prod = '0;
		sp = '0;
		rd = risc_alu_pkg::reduce_idx(ins.dest_index);
		npc = pc + 16'd1;
		off = {{9{ins.branch_offset[6]}}, ins.branch_offset};
		res = '0;
		d7 = d[7]; d3 = d[3]; s7 = 1'b0; s3 = 1'b0; r7 = 1'b0; r3 = 1'b0;
		case (ins.opcode)
			risc_alu_pkg::OP_ADD, risc_alu_pkg::OP_ADC: begin
				cin = (ins.opcode == risc_alu_pkg::OP_ADC) && sreg[risc_alu_pkg::FC];
				r = d + s + {7'd0, cin};
				s7 = s[7]; s3 = s[3]; r7 = r[7]; r3 = r[3];
				f[risc_alu_pkg::FH] = (d3 & s3) | (s3 & ~r3) | (~r3 & d3);
				f[risc_alu_pkg::FV] = (d7 & s7 & ~r7) | (~d7 & ~s7 & r7);
				f[risc_alu_pkg::FC] = (d7 & s7) | (s7 & ~r7) | (~r7 & d7);
				res.write_enable = 1'b1;
			end
			risc_alu_pkg::OP_ADIW: begin
				old = {phi, plo};
				pr = old + {10'd0, ins.immediate[5:0]};
				f[risc_alu_pkg::FV] = ~old[15] & pr[15];
				f[risc_alu_pkg::FC] = ~pr[15] & old[15];
				f[risc_alu_pkg::FN] = pr[15];
				f[risc_alu_pkg::FZ] = (pr == 16'd0);
				f[risc_alu_pkg::FS] = pr[15] ^ (~old[15] & pr[15]);
				res.pair_enable = 1'b1;
				res.pair_index = {rd[4:1], 1'b0};
				res.pair_value = pr;
			end
			risc_alu_pkg::OP_AND, risc_alu_pkg::OP_ANDI, risc_alu_pkg::OP_EOR,
			risc_alu_pkg::OP_COM, risc_alu_pkg::OP_CBR, risc_alu_pkg::OP_CLR: begin
				case (ins.opcode)
					risc_alu_pkg::OP_AND:  r = d & s;
					risc_alu_pkg::OP_ANDI: r = d & ins.immediate;
					risc_alu_pkg::OP_EOR:  r = d ^ s;
					risc_alu_pkg::OP_COM:  r = ~d;
					risc_alu_pkg::OP_CBR:  r = d & ~ins.immediate;
					default:               r = '0;
				endcase
				if (ins.opcode == risc_alu_pkg::OP_COM)
					f[risc_alu_pkg::FC] = 1'b1;
				f[risc_alu_pkg::FV] = 1'b0;
				res.write_enable = 1'b1;
			end
			risc_alu_pkg::OP_ASR: begin
				r = {d[7], d[7:1]};
				f[risc_alu_pkg::FC] = d[0];
				f[risc_alu_pkg::FV] = r[7] ^ d[0];
				res.write_enable = 1'b1;
			end
			risc_alu_pkg::OP_DEC: begin
				r = d - 8'd1;
				f[risc_alu_pkg::FV] = (r == 8'h7F);
				res.write_enable = 1'b1;
			end
			risc_alu_pkg::OP_CP, risc_alu_pkg::OP_CPC, risc_alu_pkg::OP_CPI: begin
				sub_s = (ins.opcode == risc_alu_pkg::OP_CPI) ? ins.immediate : s;
				cin = (ins.opcode == risc_alu_pkg::OP_CPC) && sreg[risc_alu_pkg::FC];
				r = d - sub_s - {7'd0, cin};
				s7 = sub_s[7]; s3 = sub_s[3]; r7 = r[7]; r3 = r[3];
				f[risc_alu_pkg::FH] = (~d3 & s3) | (s3 & r3) | (r3 & ~d3);
				f[risc_alu_pkg::FV] = (d7 & ~s7 & ~r7) | (~d7 & s7 & r7);
				f[risc_alu_pkg::FC] = (~d7 & s7) | (s7 & r7) | (r7 & ~d7);
			end
			risc_alu_pkg::OP_BSET: f[ins.bit_index] = 1'b1;
			risc_alu_pkg::OP_BCLR: f[ins.bit_index] = 1'b0;
			risc_alu_pkg::OP_BST:  f[risc_alu_pkg::FT] = d[ins.bit_index];
			risc_alu_pkg::OP_BLD: begin
				r = d;
				r[ins.bit_index] = sreg[risc_alu_pkg::FT];
				res.write_enable = 1'b1;
			end
			risc_alu_pkg::OP_BRBS: if (sreg[ins.bit_index]) npc = npc + off;
			risc_alu_pkg::OP_BRBC: if (!sreg[ins.bit_index]) npc = npc + off;
			risc_alu_pkg::OP_CPSE: if (d == s) npc = pc + 16'd2;
			risc_alu_pkg::OP_FMUL, risc_alu_pkg::OP_FMULS, risc_alu_pkg::OP_FMULSU: begin
				case (ins.opcode)
					risc_alu_pkg::OP_FMUL:
						sp = $signed({9'd0, d}) * $signed({9'd0, s});
					risc_alu_pkg::OP_FMULS:
						sp = $signed({{9{d[7]}}, d}) * $signed({{9{s[7]}}, s});
					default:
						sp = $signed({{9{d[7]}}, d}) * $signed({9'd0, s});
				endcase
				prod = sp[15:0];
				f[risc_alu_pkg::FC] = prod[15];
				f[risc_alu_pkg::FZ] = (prod[14:0] == 15'd0);
				res.pair_enable = 1'b1;
				res.pair_value = {prod[14:0], 1'b0};
			end
			risc_alu_pkg::OP_IJMP: npc = {zhi, zlo};
			default: ;
		endcase
		// shared N/Z/S update for byte results
		if (res.write_enable && ins.opcode != risc_alu_pkg::OP_BLD
			|| ins.opcode == risc_alu_pkg::OP_CP || ins.opcode == risc_alu_pkg::OP_CPC
			|| ins.opcode == risc_alu_pkg::OP_CPI) begin
			f[risc_alu_pkg::FN] = r[7];
			if (ins.opcode == risc_alu_pkg::OP_CPC)
				f[risc_alu_pkg::FZ] = (r == 8'd0) & sreg[risc_alu_pkg::FZ];
			else
				f[risc_alu_pkg::FZ] = (r == 8'd0);
			f[risc_alu_pkg::FS] = r[7] ^ f[risc_alu_pkg::FV];
		end
		if (res.write_enable) begin
			res.write_index = rd;
			res.write_value = r;
		end
		res.status_flags = f;
		res.next_pc = npc;
	end

endmodule

// File: hdl/risc_alu_regs.sv
// Architectural state: register file, status and pc, with write-back
module risc_alu_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  commit,
	input  risc_alu_pkg::result_t res,
	input  logic [4:0]            rd_a,
	input  logic [4:0]            rd_b,
	input  logic [4:0]            rd_p,
	output logic [7:0]            d,
	output logic [7:0]            s,
	output logic [7:0]            plo,
	output logic [7:0]            phi,
	output logic [7:0]            zlo,
	output logic [7:0]            zhi,
	output logic [7:0]            sreg,
	output logic [15:0]           pc
);

	logic [7:0] rf_q [risc_alu_pkg::RegCount];
	logic [4:0] ph;

	always_comb begin
		ph = risc_alu_pkg::reduce_idx(rd_p + 5'd1);
		d = rf_q[risc_alu_pkg::RegIdxW'(rd_a)];
		s = rf_q[risc_alu_pkg::RegIdxW'(rd_b)];
		plo = rf_q[risc_alu_pkg::RegIdxW'(rd_p)];
		phi = rf_q[risc_alu_pkg::RegIdxW'(ph)];
		zlo = rf_q[risc_alu_pkg::RegIdxW'(risc_alu_pkg::reduce_idx(5'd30))];
		zhi = rf_q[risc_alu_pkg::RegIdxW'(risc_alu_pkg::reduce_idx(5'd31))];
	end

	// pair high index follows the written pair
	logic [4:0] wph;
	assign wph = risc_alu_pkg::reduce_idx(res.pair_index + 5'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < risc_alu_pkg::RegCount; i++)
				rf_q[i] <= '0;
			sreg <= '0;
			pc <= '0;
		end else if (commit) begin
			for (int i = 0; i < risc_alu_pkg::RegCount; i++) begin
				if (res.write_enable && res.write_index == 5'(i))
					rf_q[i] <= res.write_value;
				if (res.pair_enable && res.pair_index == 5'(i))
					rf_q[i] <= res.pair_value[7:0];
				if (res.pair_enable && wph == 5'(i))
					rf_q[i] <= res.pair_value[15:8];
			end
			sreg <= res.status_flags;
			pc <= res.next_pc;
		end
	end

endmodule

// File: hdl/risc_8bit_alu_flags_branch_top.sv
// Executes one decoded instruction per transaction.
// s_axis: tdata = opcode, dest_index, source_index, immediate, bit_index,
//   branch_offset from bit 0 upward (33 bits, padded to 40).
// m_axis: tdata = write_enable, write_index, write_value, pair_enable,
//   pair_index, pair_value, status_flags, next_pc from bit 0 upward.
// The result is registered and appears in the cycle after its input.
// Throughput: one instruction per cycle unless stalled; register file,
// status and pc are written at the accepting edge, so the next
// instruction sees them at once. The output register accepts a new item
// whenever it is empty or being drained in the same cycle; a stalled
// receiver holds the result and s_axis_tready drops.
// Reset clears all 32 registers, the status register and the pc, and
// empties the output register.
module risc_8bit_alu_flags_branch_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// opcode, dest_index, source_index, immediate, bit_index, branch_offset
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// write_enable, write_index, write_value, pair_enable, pair_index,
	// pair_value, status_flags, next_pc
	output logic [63:0] m_axis_tdata
);

	risc_alu_pkg::instr_t  ins;
	risc_alu_pkg::result_t res;
	logic [7:0]  d, s, plo, phi, zlo, zhi, sreg;
	logic [15:0] pc;
	logic        take;
	logic [4:0]  rd_r, rd_a, rd_b;
	logic [63:0] out_q;
	logic        vld_q;

	assign ins.opcode        = s_axis_tdata[4:0];
	assign ins.dest_index    = s_axis_tdata[9:5];
	assign ins.source_index  = s_axis_tdata[14:10];
	assign ins.immediate     = s_axis_tdata[22:15];
	assign ins.bit_index     = s_axis_tdata[25:23];
	assign ins.branch_offset = s_axis_tdata[32:26];

	assign s_axis_tready = !vld_q || m_axis_tready;
	assign take = s_axis_tvalid && s_axis_tready;

	assign rd_a = risc_alu_pkg::reduce_idx(ins.dest_index);
	assign rd_b = risc_alu_pkg::reduce_idx(ins.source_index);
	assign rd_r = {rd_a[4:1], 1'b0};

	risc_alu_regs u_regs (
		.clk(clk), .arst_n(arst_n), .commit(take), .res(res),
		.rd_a(rd_a), .rd_b(rd_b), .rd_p(rd_r),
		.d(d), .s(s), .plo(plo), .phi(phi), .zlo(zlo), .zhi(zhi),
		.sreg(sreg), .pc(pc)
	);

	risc_alu_exec u_exec (
		.ins(ins), .d(d), .s(s), .plo(plo), .phi(phi), .zlo(zlo), .zhi(zhi),
		.sreg(sreg), .pc(pc), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (s_axis_tready)
			vld_q <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (take)
			out_q <= {4'd0, res.next_pc, res.status_flags, res.pair_value,
				res.pair_index, res.pair_enable, res.write_value,
				res.write_index, res.write_enable};
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = out_q;

endmodule

// File: hdl/risc_alu_checker.sv
`include "assert_macros.svh"

module risc_alu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	`ASSERT_NEXT(a_accept_gives_out, clk, arst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
	`ASSERT_IMPLIES(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	`ASSERT_NEXT(a_hold_on_stall, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && m_axis_tvalid)
	`ASSERT_IMPLIES(a_we_idx_zero, clk, arst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[13:1] == 13'd0)

endmodule

bind risc_8bit_alu_flags_branch_top risc_alu_checker u_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// File: bench/risc_8bit_alu_flags_branch_top_tb.sv
`timescale 1ns / 1ps

module risc_8bit_alu_flags_branch_top_tb;

	localparam logic [4:0] OP_SPARE = 5'd31;
	localparam int WatchdogLimit = 3000;
	localparam int HoldCycles = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;

	risc_8bit_alu_flags_branch_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #6 clk = ~clk;

	// shadow machine state
	logic [7:0]  regs [32];
	logic [7:0]  sreg;
	logic [15:0] pc;
	logic [63:0] pending_results [$];
	bit          failed = 0;
	int          idle_cycles = 0;
	int          accepted_count = 0;

	typedef struct {
		logic [4:0] op;
		logic [4:0] rd;
		logic [4:0] rr;
		logic [7:0] k;
		logic [2:0] b;
		logic [6:0] off;
		bit         typed;
		logic [63:0] result;
	} stim_row_t;

	function automatic logic [39:0] pack_instr(logic [4:0] op, logic [4:0] rd, logic [4:0] rr,
			logic [7:0] k, logic [2:0] b, logic [6:0] off);
		return {7'b0, off, b, k, rr, rd, op};
	endfunction

	function automatic logic [63:0] pack_result(logic we, logic [4:0] wi, logic [7:0] wv,
			logic pe, logic [4:0] pi, logic [15:0] pv, logic [7:0] f, logic [15:0] npc);
		return {4'b0, npc, f, pv, pi, pe, wv, wi, we};
	endfunction

	function automatic logic [7:0] set_nzs(logic [7:0] f, logic [7:0] r);
		f[risc_alu_pkg::FN] = r[7];
		f[risc_alu_pkg::FZ] = (r == 8'h00);
		f[risc_alu_pkg::FS] = f[risc_alu_pkg::FN] ^ f[risc_alu_pkg::FV];
		return f;
	endfunction

	function automatic logic [7:0] sum_flags(logic [7:0] f, logic [7:0] d, logic [7:0] s,
			logic [7:0] r);
		f[risc_alu_pkg::FH] = (d[3] & s[3]) | (s[3] & ~r[3]) | (~r[3] & d[3]);
		f[risc_alu_pkg::FV] = (d[7] & s[7] & ~r[7]) | (~d[7] & ~s[7] & r[7]);
		f[risc_alu_pkg::FC] = (d[7] & s[7]) | (s[7] & ~r[7]) | (~r[7] & d[7]);
		return set_nzs(f, r);
	endfunction

	function automatic logic [7:0] diff_flags(logic [7:0] f, logic [7:0] d, logic [7:0] s,
			logic cin, logic keep_z);
		logic [7:0] r;
		logic old_z;
		old_z = f[risc_alu_pkg::FZ];
		r = d - s - cin;
		f[risc_alu_pkg::FH] = (~d[3] & s[3]) | (s[3] & r[3]) | (r[3] & ~d[3]);
		f[risc_alu_pkg::FV] = (d[7] & ~s[7] & ~r[7]) | (~d[7] & s[7] & r[7]);
		f[risc_alu_pkg::FC] = (~d[7] & s[7]) | (s[7] & r[7]) | (r[7] & ~d[7]);
		f = set_nzs(f, r);
		if (keep_z)
			f[risc_alu_pkg::FZ] = (r == 8'h00) & old_z;
		return f;
	endfunction

	// executes one instruction on the shadow state, returns the packed result
	function automatic logic [63:0] execute(logic [39:0] t);
		logic [4:0] op, rd, rr, lo;
		logic [7:0] k, d, s, wv, f;
		logic [2:0] b;
		logic [15:0] off, npc, pv, old, prod;
		logic we, pe;
		op = t[4:0]; rd = t[9:5]; rr = t[14:10]; k = t[22:15]; b = t[25:23];
		off = {{9{t[32]}}, t[32:26]};
		d = regs[rd]; s = regs[rr]; f = sreg;
		we = 0; pe = 0; wv = 0; lo = 0; pv = 0;
		npc = pc + 16'd1;
		case (op)
			risc_alu_pkg::OP_ADD: begin
				we = 1; wv = d + s; f = sum_flags(f, d, s, wv);
			end
			risc_alu_pkg::OP_ADC: begin
				we = 1; wv = d + s + f[risc_alu_pkg::FC]; f = sum_flags(f, d, s, wv);
			end
			risc_alu_pkg::OP_ADIW: begin
				lo = {rd[4:1], 1'b0};
				old = {regs[lo + 5'd1], regs[lo]};
				pv = old + {10'b0, k[5:0]};
				f[risc_alu_pkg::FV] = ~old[15] & pv[15];
				f[risc_alu_pkg::FC] = ~pv[15] & old[15];
				f[risc_alu_pkg::FN] = pv[15];
				f[risc_alu_pkg::FZ] = (pv == 16'h0000);
				f[risc_alu_pkg::FS] = f[risc_alu_pkg::FN] ^ f[risc_alu_pkg::FV];
				pe = 1;
			end
			risc_alu_pkg::OP_AND: begin
				we = 1; wv = d & s; f[risc_alu_pkg::FV] = 0; f = set_nzs(f, wv);
			end
			risc_alu_pkg::OP_ANDI: begin
				we = 1; wv = d & k; f[risc_alu_pkg::FV] = 0; f = set_nzs(f, wv);
			end
			risc_alu_pkg::OP_EOR: begin
				we = 1; wv = d ^ s; f[risc_alu_pkg::FV] = 0; f = set_nzs(f, wv);
			end
			risc_alu_pkg::OP_COM: begin
				we = 1; wv = ~d; f[risc_alu_pkg::FC] = 1; f[risc_alu_pkg::FV] = 0;
				f = set_nzs(f, wv);
			end
			risc_alu_pkg::OP_ASR: begin
				we = 1; wv = {d[7], d[7:1]};
				f[risc_alu_pkg::FC] = d[0];
				f[risc_alu_pkg::FN] = wv[7];
				f[risc_alu_pkg::FV] = f[risc_alu_pkg::FN] ^ f[risc_alu_pkg::FC];
				f[risc_alu_pkg::FZ] = (wv == 8'h00);
				f[risc_alu_pkg::FS] = f[risc_alu_pkg::FN] ^ f[risc_alu_pkg::FV];
			end
			risc_alu_pkg::OP_DEC: begin
				we = 1; wv = d - 8'd1; f[risc_alu_pkg::FV] = (wv == 8'h7F);
				f = set_nzs(f, wv);
			end
			risc_alu_pkg::OP_CP:   f = diff_flags(f, d, s, 1'b0, 1'b0);
			risc_alu_pkg::OP_CPC:  f = diff_flags(f, d, s, f[risc_alu_pkg::FC], 1'b1);
			risc_alu_pkg::OP_CPI:  f = diff_flags(f, d, k, 1'b0, 1'b0);
			risc_alu_pkg::OP_CBR: begin
				we = 1; wv = d & ~k; f[risc_alu_pkg::FV] = 0; f = set_nzs(f, wv);
			end
			risc_alu_pkg::OP_CLR: begin
				we = 1; wv = 8'h00; f[risc_alu_pkg::FV] = 0; f = set_nzs(f, wv);
			end
			risc_alu_pkg::OP_BSET: f[b] = 1'b1;
			risc_alu_pkg::OP_BCLR: f[b] = 1'b0;
			risc_alu_pkg::OP_BST:  f[risc_alu_pkg::FT] = d[b];
			risc_alu_pkg::OP_BLD: begin
				we = 1; wv = d; wv[b] = f[risc_alu_pkg::FT];
			end
			risc_alu_pkg::OP_BRBS: if (f[b]) npc = npc + off;
			risc_alu_pkg::OP_BRBC: if (!f[b]) npc = npc + off;
			risc_alu_pkg::OP_CPSE: if (d == s) npc = pc + 16'd2;
			risc_alu_pkg::OP_FMUL, risc_alu_pkg::OP_FMULS, risc_alu_pkg::OP_FMULSU: begin
				if (op == risc_alu_pkg::OP_FMUL)
					prod = {8'b0, d} * {8'b0, s};
				else if (op == risc_alu_pkg::OP_FMULS)
					prod = {{8{d[7]}}, d} * {{8{s[7]}}, s};
				else
					prod = {{8{d[7]}}, d} * {8'b0, s};
				pv = prod << 1;
				f[risc_alu_pkg::FC] = prod[15];
				f[risc_alu_pkg::FZ] = (pv == 16'h0000);
				pe = 1;
			end
			risc_alu_pkg::OP_IJMP: npc = {regs[31], regs[30]};
			default: ;
		endcase
		if (we)
			regs[rd] = wv;
		if (pe) begin
			regs[lo] = pv[7:0];
			regs[lo + 5'd1] = pv[15:8];
		end
		sreg = f;
		pc = npc;
		return pack_result(we, we ? rd : 5'd0, wv, pe, lo, pv, f, npc);
	endfunction

	function automatic void compare_result(logic [63:0] want, logic [63:0] got);
		int lsb [8] = '{0, 1, 6, 14, 15, 20, 36, 44};
		int wid [8] = '{1, 5, 8, 1, 5, 16, 8, 16};
		string nm [8] = '{"write_enable", "write_index", "write_value", "pair_enable",
			"pair_index", "pair_value", "status_flags", "next_pc"};
		logic [15:0] e, a;
		for (int i = 0; i < 8; i++) begin
			e = 16'((want >> lsb[i]) & ((64'd1 << wid[i]) - 1));
			a = 16'((got >> lsb[i]) & ((64'd1 << wid[i]) - 1));
			if (e !== a) begin
				$display("%0t mismatch %s: expected %h, actual %h", $realtime, nm[i], e, a);
				failed = 1;
			end
		end
	endfunction

	// directed table: first two rows carry results read straight off the state after reset
	stim_row_t directed [] = '{
		'{risc_alu_pkg::OP_ADD, 0, 0, 0, 0, 0, 1,
			pack_result(1, 0, 8'h00, 0, 0, 0, 8'h02, 16'd1)},
		'{risc_alu_pkg::OP_COM, 1, 0, 0, 0, 0, 1,
			pack_result(1, 1, 8'hFF, 0, 0, 0, 8'h15, 16'd2)},
		'{risc_alu_pkg::OP_DEC, 2, 0, 0, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_ADIW, 31, 0, 8'hFF, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_ADIW, 24, 0, 8'd63, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_ASR, 1, 0, 0, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_ADD, 2, 1, 0, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_ADC, 2, 31, 0, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_CP, 0, 1, 0, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_CPC, 0, 0, 0, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_CPI, 3, 0, 8'hFF, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_AND, 2, 1, 0, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_ANDI, 1, 0, 8'h80, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_EOR, 1, 2, 0, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_CBR, 2, 0, 8'h0F, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_BSET, 0, 0, 0, 3'd7, 0, 0, '0},
		'{risc_alu_pkg::OP_BST, 2, 0, 0, 3'd7, 0, 0, '0},
		'{risc_alu_pkg::OP_BLD, 3, 0, 0, 3'd0, 0, 0, '0},
		'{risc_alu_pkg::OP_BRBS, 0, 0, 0, 3'd6, 7'h40, 0, '0},
		'{risc_alu_pkg::OP_BRBC, 0, 0, 0, 3'd0, 7'h3F, 0, '0},
		'{risc_alu_pkg::OP_CPSE, 5, 6, 0, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_FMUL, 1, 1, 0, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_FMULS, 2, 31, 0, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_FMULSU, 3, 2, 0, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_CLR, 31, 0, 0, 0, 0, 0, '0},
		'{risc_alu_pkg::OP_BCLR, 0, 0, 0, 3'd7, 0, 0, '0},
		'{risc_alu_pkg::OP_IJMP, 0, 0, 0, 0, 0, 0, '0},
		'{OP_SPARE, 31, 31, 8'hFF, 3'd7, 7'h7F, 0, '0}
	};

	// scoreboard: sampled at the edge, before any update of that edge lands
	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				want = execute(s_axis_tdata);
				// directed rows are the first transactions, in table order
				if (accepted_count < directed.size() && directed[accepted_count].typed)
					want = directed[accepted_count].result;
				accepted_count++;
				pending_results.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$display("%0t unexpected transaction: expected none, actual %h",
						$realtime, m_axis_tdata);
					failed = 1;
				end else begin
					compare_result(pending_results.pop_front(), m_axis_tdata);
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WatchdogLimit) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver: stall pattern re-drawn from four modes, one long hold-off
	initial begin
		int cyc;
		int mode;
		cyc = 0;
		mode = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (cyc == 300) begin
				m_axis_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				cyc++;
			end
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= cyc[2];
			endcase
			@(posedge clk);
			cyc++;
		end
	end

	task automatic offer(logic [39:0] t);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= t;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic maybe_gap(inout int burst_left);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 40);
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int burst_left;
		logic [4:0] op;
		burst_left = 0;
		for (int i = 0; i < 32; i++)
			regs[i] = 8'h00;
		sreg = 8'h00;
		pc = 16'h0000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			offer(pack_instr(directed[i].op, directed[i].rd, directed[i].rr, directed[i].k,
				directed[i].b, directed[i].off));
			maybe_gap(burst_left);
		end

		for (int n = 0; n < 1350; n++) begin
			if (n == 600) begin
				// drain completely before going on
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			op = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(0, 24));
			offer(pack_instr(op, 5'($urandom), 5'($urandom), 8'($urandom),
				3'($urandom), 7'($urandom)));
			maybe_gap(burst_left);
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (!failed)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/risc_alu_pkg.sv
hdl/risc_alu_exec.sv
hdl/risc_alu_regs.sv
hdl/risc_8bit_alu_flags_branch_top.sv
hdl/risc_alu_checker.sv
bench/risc_8bit_alu_flags_branch_top_tb.sv
